// ----- rtl/mesp_pkg.sv -----
package mesp_pkg;

    // Parser position within one event.
    typedef enum logic [2:0] {
        PH_START,
        PH_DATA,
        PH_DELAY,
        PH_CHECK,
        PH_ENDED
    } t_phase;

    // Work handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_EMIT,
        OP_ADD240,
        OP_TEMPO
    } t_op;

    // One queue entry. For a tempo command the note field carries the
    // multiplier byte and the volume field carries the fraction byte.
    typedef struct packed {
        t_op         op;
        logic [3:0]  kind;
        logic [3:0]  voice;
        logic [7:0]  note;
        logic [7:0]  volume;
        logic [7:0]  instrument;
        logic [14:0] pitch;
        logic [7:0]  dly;
    } t_cmd;

    // Result kinds.
    localparam logic [3:0] KIND_RESTART = 4'd0;
    localparam logic [3:0] KIND_NOTE_ON = 4'd1;
    localparam logic [3:0] KIND_NOTE_OFF = 4'd2;
    localparam logic [3:0] KIND_VOLUME = 4'd3;
    localparam logic [3:0] KIND_INSTR = 4'd4;
    localparam logic [3:0] KIND_PITCH = 4'd5;
    localparam logic [3:0] KIND_TEMPO = 4'd6;
    localparam logic [3:0] KIND_OTHER = 4'd7;
    localparam logic [3:0] KIND_END_STOP = 4'd8;
    localparam logic [3:0] KIND_END_REWOUND = 4'd9;

    // Status high-nibble codes.
    localparam logic [3:0] NIB_RESTART = 4'h8;
    localparam logic [3:0] NIB_NOTE = 4'h9;
    localparam logic [3:0] NIB_VOLUME = 4'hA;
    localparam logic [3:0] NIB_INSTR = 4'hC;
    localparam logic [3:0] NIB_PITCH = 4'hE;
    localparam logic [3:0] NIB_TEMPO = 4'hF;

    // Stream codes.
    localparam logic [7:0] END_CODE = 8'hFC;
    localparam logic [7:0] DELAY_EXT = 8'hF8;
    localparam logic [7:0] DELAY_EXT_ADD = 8'd240;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TEMPO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SONG = 1'b1;
    localparam logic [7:0] BASE_TEMPO_RST = 8'd120;

    // Command queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Number of data bytes that follow a status byte.
    function automatic logic [2:0] data_count(input logic [7:0] st);
        logic [2:0] cnt;
        case (st[7:4])
            NIB_RESTART, NIB_NOTE, NIB_PITCH: cnt = 3'd2;
            NIB_VOLUME, NIB_INSTR: cnt = 3'd1;
            NIB_TEMPO: cnt = 3'd5;
            default: cnt = 3'd0;
        endcase
        return cnt;
    endfunction

    // 16-bit add of an 8-bit value, saturating at all ones.
    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ----- rtl/mesp_front.sv -----
module mesp_front
    import mesp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_repeat_song,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_rs, n_rs;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_args [4];
    logic [7:0]  n_args [4];
    logic [7:0]  r_pend, n_pend;

    logic        in_fire;
    logic        do_begin;
    logic        do_take;
    logic [2:0]  take_idx;
    logic [2:0]  cur_cnt;
    logic [3:0]  ev_kind;
    logic [7:0]  ev_note;
    logic [7:0]  ev_volume;
    logic [7:0]  ev_instr;
    logic [14:0] ev_pitch;

    assign in_fire = i_in_valid && !i_full;
    assign cur_cnt = data_count(r_rs);

    // Classify the event held in the running status and the stored data bytes.
    always_comb begin
        ev_kind = KIND_OTHER;
        ev_note = 8'd0;
        ev_volume = 8'd0;
        ev_instr = 8'd0;
        ev_pitch = 15'd0;
        case (r_rs[7:4])
            NIB_RESTART: begin
                ev_kind = KIND_RESTART;
                ev_note = r_args[0];
                ev_volume = r_args[1];
            end
            NIB_NOTE: begin
                ev_kind = (r_args[1] != 8'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
                ev_note = r_args[0];
                ev_volume = r_args[1];
            end
            NIB_VOLUME: begin
                ev_kind = KIND_VOLUME;
                ev_volume = r_args[0];
            end
            NIB_INSTR: begin
                ev_kind = KIND_INSTR;
                ev_instr = r_args[0];
            end
            NIB_PITCH: begin
                ev_kind = KIND_PITCH;
                ev_pitch = {r_args[1], r_args[0][7:1]};
            end
            NIB_TEMPO: begin
                ev_kind = KIND_TEMPO;
            end
            default: begin
                ev_kind = KIND_OTHER;
            end
        endcase
    end

    // Next parser state and the command that this beat sends to the back part.
    always_comb begin
        n_phase = r_phase;
        n_rs = r_rs;
        n_idx = r_idx;
        n_args = r_args;
        n_pend = r_pend;
        do_begin = 1'b0;
        do_take = 1'b0;
        take_idx = r_idx;
        o_push = 1'b0;
        o_cmd.op = OP_EMIT;
        o_cmd.kind = ev_kind;
        o_cmd.voice = r_rs[3:0];
        o_cmd.note = ev_note;
        o_cmd.volume = ev_volume;
        o_cmd.instrument = ev_instr;
        o_cmd.pitch = ev_pitch;
        o_cmd.dly = r_pend;

        if (in_fire) begin
            case (r_phase)
                PH_START: begin
                    do_begin = 1'b1;
                end
                PH_DATA: begin
                    do_take = 1'b1;
                end
                PH_DELAY: begin
                    n_pend = i_data_byte;
                    n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    if (i_data_byte == END_CODE) begin
                        o_push = 1'b1;
                        o_cmd.kind = i_repeat_song ? KIND_END_REWOUND : KIND_END_STOP;
                        n_phase = i_repeat_song ? PH_START : PH_ENDED;
                    end else if (r_pend == DELAY_EXT) begin
                        o_push = 1'b1;
                        o_cmd.op = OP_ADD240;
                        n_pend = i_data_byte;
                    end else begin
                        o_push = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                PH_ENDED: begin
                    n_phase = PH_ENDED;
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end

        // Start of an event: a status byte, or a byte under running status.
        if (do_begin) begin
            if (i_data_byte[7]) begin
                n_rs = i_data_byte;
                n_idx = 3'd0;
                n_phase = (data_count(i_data_byte) != 3'd0) ? PH_DATA : PH_DELAY;
            end else if (cur_cnt == 3'd0) begin
                n_pend = i_data_byte;
                n_phase = PH_CHECK;
            end else begin
                do_take = 1'b1;
                take_idx = 3'd0;
            end
        end

        // Store a data byte; the fourth tempo byte completes the new tempo.
        if (do_take) begin
            if (!take_idx[2]) begin
                n_args[take_idx[1:0]] = i_data_byte;
            end
            if (r_rs[7:4] == NIB_TEMPO && take_idx == 3'd3) begin
                o_push = 1'b1;
                o_cmd.op = OP_TEMPO;
                o_cmd.note = r_args[2];
                o_cmd.volume = i_data_byte;
            end
            if (({1'b0, take_idx} + 4'd1) >= {1'b0, cur_cnt}) begin
                n_phase = PH_DELAY;
            end else begin
                n_phase = PH_DATA;
                n_idx = take_idx + 3'd1;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_rs <= 8'd0;
            r_idx <= 3'd0;
            r_args <= '{default: 8'd0};
            r_pend <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_rs <= n_rs;
            r_idx <= n_idx;
            r_args <= n_args;
            r_pend <= n_pend;
        end
    end

endmodule

// ----- rtl/mesp_cmd_fifo.sv -----
module mesp_cmd_fifo
    import mesp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_full = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/mesp_back.sv -----
module mesp_back
    import mesp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_base_tempo,
    input  t_cmd        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_kind,
    output logic [3:0]  o_voice,
    output logic [7:0]  o_note,
    output logic [7:0]  o_volume,
    output logic [7:0]  o_instrument,
    output logic [14:0] o_pitch,
    output logic [15:0] o_tempo,
    output logic [15:0] o_delay,
    output logic [31:0] o_tick
);

    logic [15:0] r_delay_sum, n_delay_sum;
    logic [31:0] r_tick, n_tick;
    logic [15:0] r_tempo, n_tempo;
    logic        r_out_valid, n_out_valid;
    logic [3:0]  r_kind;
    logic [3:0]  r_voice;
    logic [7:0]  r_note;
    logic [7:0]  r_volume;
    logic [7:0]  r_instr;
    logic [14:0] r_pitch;
    logic [15:0] r_out_tempo;
    logic [15:0] r_out_delay;
    logic [31:0] r_out_tick;

    logic        slot_free;
    logic        emit;
    logic        rewind;
    logic [15:0] prod_a;
    logic [15:0] prod_b;
    logic [15:0] tempo_calc;
    logic [15:0] dly_total;
    logic [31:0] tick_sum;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop = !i_empty && (i_head.op != OP_EMIT || slot_free);
    assign emit = o_pop && i_head.op == OP_EMIT;
    assign rewind = (i_head.kind == KIND_END_REWOUND);

    // Tempo = base * a + base * b / 128.
    assign prod_a = {8'd0, i_base_tempo} * {8'd0, i_head.note};
    assign prod_b = {8'd0, i_base_tempo} * {8'd0, i_head.volume};
    assign tempo_calc = prod_a + {7'd0, prod_b[15:7]};

    // Closing delay and running tick count.
    assign dly_total = sat16(r_delay_sum, i_head.dly);
    assign tick_sum = r_tick + {16'd0, dly_total};

    // Next values of the timing state and the result slot.
    always_comb begin
        n_delay_sum = r_delay_sum;
        n_tick = r_tick;
        n_tempo = r_tempo;
        n_out_valid = r_out_valid && i_out_stall;
        if (o_pop) begin
            case (i_head.op)
                OP_ADD240: begin
                    n_delay_sum = sat16(r_delay_sum, DELAY_EXT_ADD);
                end
                OP_TEMPO: begin
                    n_tempo = tempo_calc;
                end
                OP_EMIT: begin
                    n_delay_sum = 16'd0;
                    n_out_valid = 1'b1;
                    if (rewind) begin
                        n_tick = 32'd0;
                        n_tempo = {8'd0, i_base_tempo};
                    end else begin
                        n_tick = tick_sum;
                    end
                end
                default: begin
                    n_delay_sum = r_delay_sum;
                end
            endcase
        end
    end

    // Timing state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_sum <= 16'd0;
            r_tick <= 32'd0;
            r_tempo <= {8'd0, BASE_TEMPO_RST};
            r_out_valid <= 1'b0;
        end else begin
            r_delay_sum <= n_delay_sum;
            r_tick <= n_tick;
            r_tempo <= n_tempo;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded when an event is emitted.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= i_head.kind;
            r_voice <= i_head.voice;
            r_note <= i_head.note;
            r_volume <= i_head.volume;
            r_instr <= i_head.instrument;
            r_pitch <= i_head.pitch;
            r_out_delay <= dly_total;
            r_out_tempo <= rewind ? {8'd0, i_base_tempo} : r_tempo;
            r_out_tick <= rewind ? 32'd0 : tick_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_voice = r_voice;
    assign o_note = r_note;
    assign o_volume = r_volume;
    assign o_instrument = r_instr;
    assign o_pitch = r_pitch;
    assign o_tempo = r_out_tempo;
    assign o_delay = r_out_delay;
    assign o_tick = r_out_tick;

endmodule

// ----- rtl/music_event_stream_parser.sv -----
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_stall    | i_data_byte
// output   | out       | o_out_valid / i_out_stall  | event, voice, args, tempo, delay, tick
// config   | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One byte beat is taken every cycle while the command queue has room.
// The back part retires one queued command per cycle while no event waits on a stalled
// result; an event passes from the command queue into the result register.
// Synchronous active-low reset; tempo returns to 120 and the tick count to 0.
// A stalled result holds; the four-entry queue absorbs beats behind it, and
// o_in_stall rises once the queue is full.
module music_event_stream_parser
    import mesp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [3:0]           o_event_kind,
    output logic [3:0]           o_voice,
    output logic [7:0]           o_note,
    output logic [7:0]           o_volume,
    output logic [7:0]           o_instrument,
    output logic [14:0]          o_pitch,
    output logic [15:0]          o_tempo,
    output logic [15:0]          o_delay,
    output logic [31:0]          o_tick
);

    logic [7:0] r_base_tempo;
    logic       r_repeat_song;
    logic       w_push;
    t_cmd       w_push_cmd;
    logic       w_full;
    logic       w_pop;
    t_cmd       w_head;
    logic       w_empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_tempo <= BASE_TEMPO_RST;
            r_repeat_song <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_TEMPO: r_base_tempo <= i_cfg_data;
                CFG_REPEAT_SONG: r_repeat_song <= i_cfg_data[0];
                default: r_base_tempo <= r_base_tempo;
            endcase
        end
    end

    assign o_in_stall = w_full;

    // Byte parser.
    mesp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_repeat_song (r_repeat_song),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    // Command queue between parser and timing unit.
    mesp_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_empty    (w_empty)
    );

    // Delay, tick and tempo unit with the result register.
    mesp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_base_tempo (r_base_tempo),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_voice      (o_voice),
        .o_note       (o_note),
        .o_volume     (o_volume),
        .o_instrument (o_instrument),
        .o_pitch      (o_pitch),
        .o_tempo      (o_tempo),
        .o_delay      (o_delay),
        .o_tick       (o_tick)
    );

    // The parser never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into full queue");

    // The back part never retires from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from empty queue");

    // An event is never retired over a result that is still stalled.
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_head.op == OP_EMIT) |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    // A beat that is stalled at the output stays valid in the next cycle.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_tick)))
        else $error("stalled result lost");

endmodule
